>>> hw/rtl/ise_pkg.sv
// Shared types and constants of the integer stack engine.
`default_nettype none

package ise_pkg;

	localparam int unsigned StackDepthDefault = 64;
	localparam int unsigned WordWidth = 32;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_DUMP = 3'd1,
		OP_PEEK = 3'd2,
		OP_POP  = 3'd3,
		OP_ADD  = 3'd4
	} ise_op_t;

	typedef enum logic [2:0] {
		ST_ACK        = 3'd0,
		ST_VALUE      = 3'd1,
		ST_PEEK_EMPTY = 3'd2,
		ST_POP_EMPTY  = 3'd3,
		ST_ADD_SHORT  = 3'd4,
		ST_OVERFLOW   = 3'd5
	} ise_status_t;

	typedef struct packed {
		ise_op_t                       operation;
		logic signed [WordWidth-1:0]   push_value;
	} ise_req_t;

	typedef struct packed {
		ise_status_t                   status;
		logic signed [WordWidth-1:0]   value;
		logic                          last;
	} ise_res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        push;        // write request value at count, count + 1
		logic        pop;         // count - 1
		logic        rd_top;      // read entry count - 1, walk index to count - 1
		logic        rd_second;   // keep top operand, read entry count - 2
		logic        rd_next;     // read entry index - 1, index - 1
		logic        add_wb;      // write sum to entry count - 2, count - 1
		logic        emit;        // load the result register
		ise_status_t emit_status;
		logic        emit_value;  // value from read data, else zero
		logic        emit_walk;   // last flag from walk index, else one
	} ise_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic short_stack;
		logic idx_zero;
		logic out_free;
	} ise_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ise_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ise_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output      logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ise_ctrl.sv
// Controller state machine of the integer stack engine.
`default_nettype none

module ise_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire ise_pkg::ise_op_t op,
	output      logic             req_stall,
	input  wire ise_pkg::ise_sts_t sts,
	output      ise_pkg::ise_cmd_t cmd
);
	import ise_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD_A,
		S_ADD_B,
		S_READ_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   walking_q;
	logic   walking_d;

	assign req_stall = !((state_q == S_IDLE) && sts.out_free);

	always_comb begin
		cmd       = '0;
		cmd.emit_status = ST_ACK;
		state_d   = state_q;
		walking_d = walking_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && sts.out_free) begin
					cmd.emit = 1'b1;
					case (op)
						OP_PUSH: begin
							if (sts.full) begin
								cmd.emit_status = ST_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						OP_DUMP: begin
							if (!sts.empty) begin
								cmd.emit   = 1'b0;
								cmd.rd_top = 1'b1;
								walking_d  = 1'b1;
								state_d    = S_READ_OUT;
							end
						end
						OP_PEEK: begin
							if (sts.empty) begin
								cmd.emit_status = ST_PEEK_EMPTY;
							end else begin
								cmd.emit   = 1'b0;
								cmd.rd_top = 1'b1;
								walking_d  = 1'b0;
								state_d    = S_READ_OUT;
							end
						end
						OP_POP: begin
							if (sts.empty) begin
								cmd.emit_status = ST_POP_EMPTY;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						OP_ADD: begin
							if (sts.short_stack) begin
								cmd.emit_status = ST_ADD_SHORT;
							end else begin
								cmd.emit   = 1'b0;
								cmd.rd_top = 1'b1;
								state_d    = S_ADD_A;
							end
						end
						default: begin
							cmd.emit_status = ST_ACK;
						end
					endcase
				end
			end
			S_ADD_A: begin
				cmd.rd_second = 1'b1;
				state_d       = S_ADD_B;
			end
			S_ADD_B: begin
				if (sts.out_free) begin
					cmd.add_wb = 1'b1;
					cmd.emit   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_READ_OUT: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_VALUE;
					cmd.emit_value  = 1'b1;
					cmd.emit_walk   = walking_q;
					if (!walking_q || sts.idx_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			walking_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			walking_q <= walking_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ise_dp.sv
// Datapath of the integer stack engine: stack memory, count, walk index and result register.
`default_nettype none

module ise_dp #(
	parameter int unsigned STACK_DEPTH = ise_pkg::StackDepthDefault
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [ise_pkg::WordWidth-1:0]        push_value,
	input  wire ise_pkg::ise_cmd_t                    cmd,
	output      ise_pkg::ise_sts_t                    sts,
	output      logic                                 res_valid,
	input  wire logic                                 res_stall,
	output      ise_pkg::ise_res_t                    res
);
	import ise_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_m1;
	logic [CW-1:0]        count_m2;
	logic [AW-1:0]        idx_q;
	logic [WordWidth-1:0] operand_q;
	logic [WordWidth-1:0] rdata;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WordWidth-1:0] wdata;
	logic                 re;
	logic [AW-1:0]        raddr;
	logic                 res_valid_q;
	ise_res_t             res_q;

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);

	assign sts.empty       = (count_q == '0);
	assign sts.full        = (count_q == CW'(STACK_DEPTH));
	assign sts.short_stack = (count_q < CW'(2));
	assign sts.idx_zero    = (idx_q == '0);
	assign sts.out_free    = !res_valid_q || !res_stall;

	always_comb begin
		we    = cmd.push || cmd.add_wb;
		waddr = cmd.push ? count_q[AW-1:0] : count_m2[AW-1:0];
		wdata = cmd.push ? push_value : rdata + operand_q;
		re    = cmd.rd_top || cmd.rd_second || cmd.rd_next;
		if (cmd.rd_second) begin
			raddr = count_m2[AW-1:0];
		end else if (cmd.rd_next) begin
			raddr = idx_q - AW'(1);
		end else begin
			raddr = count_m1[AW-1:0];
		end
	end

	ise_ram #(
		.WIDTH(WordWidth),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop || cmd.add_wb) begin
				count_q <= count_m1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_top) begin
			idx_q <= count_m1[AW-1:0];
		end else if (cmd.rd_next) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.rd_second) begin
			operand_q <= rdata;
		end
		if (cmd.emit) begin
			res_q.status <= cmd.emit_status;
			res_q.value  <= cmd.emit_value ? rdata : '0;
			res_q.last   <= cmd.emit_walk ? (idx_q == '0) : 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/integer_stack_engine.sv
// Top level of the integer stack engine: controller, datapath and ports.
`default_nettype none

// The integer stack engine runs stack-machine opcodes (push, dump, peek, pop,
// add) over a stack of up to STACK_DEPTH signed 32-bit integers held in a
// single-port-read memory. Each request on the cmd channel gives one or more
// results on the res channel; the final result of a request carries last.
// Push, pop, every error case and unused opcodes give a single result. Peek
// passes through a read-out state, because the top entry comes out of the
// memory's registered read port in the cycle after its address. Add reads
// the two operands one after the other through that same port, then writes
// the sum back. Dump reads the top entry to start and then gives one element
// per cycle from top to bottom while the result register is not stalled.
// Requests are taken only between operations. A result register drives the
// res channel. The next request may be taken in the cycle that the previous
// result is taken by the receiver. It is not taken while that result still
// waits on a stalled receiver.
// The stack memory needs no clearing after reset; only entries below the
// element count are ever read.

module integer_stack_engine #(
	parameter int unsigned STACK_DEPTH = ise_pkg::StackDepthDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output      logic              cmd_stall,
	input  wire ise_pkg::ise_req_t cmd,
	output      logic              res_valid,
	input  wire logic              res_stall,
	output      ise_pkg::ise_res_t res
);
	import ise_pkg::*;

	// Command and status groups between the controller and the datapath.
	ise_cmd_t dp_cmd;
	ise_sts_t dp_sts;

	// The controller decodes the opcode of a request directly from the port
	// and accepts it only while idle with room in the result register.
	ise_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(cmd_valid),
		.op       (cmd.operation),
		.req_stall(cmd_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// The datapath writes a pushed value in the same cycle that the request
	// is accepted, so the push value is taken straight from the port.
	ise_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_value(cmd.push_value),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

>>> dv/integer_stack_engine_tb.sv
// Self-checking testbench for the integer stack engine with a scoreboard and random handshakes.
`timescale 1ns / 1ps

module integer_stack_engine_tb;
	import ise_pkg::*;

	localparam int unsigned Depth       = StackDepthDefault;
	localparam int unsigned ClkPeriod   = 8;
	localparam int unsigned ResetCycles = 7;
	// A full dump against a receiver that stalls now and then still ends well inside this.
	localparam int unsigned TailCycles  = 4 * Depth + 32;
	// Worst case is every request dumping a full stack with each element waiting out a
	// long stall; the limit sits well above that.
	localparam int unsigned CycleLimit  = 3_000_000;

	// Opcodes that the package leaves unnamed; the engine answers them with a plain ack.
	localparam logic [2:0] OpSpare5 = 3'd5;
	localparam logic [2:0] OpSpare6 = 3'd6;
	localparam logic [2:0] OpSpare7 = 3'd7;

	localparam logic signed [WordWidth-1:0] WordMax  = 32'sh7FFF_FFFF;
	localparam logic signed [WordWidth-1:0] WordMin  = 32'sh8000_0000;
	localparam logic signed [WordWidth-1:0] WordOnes = 32'shFFFF_FFFF;
	localparam logic signed [WordWidth-1:0] WordZero = 32'sh0000_0000;

	// Operation mixes for the random part: one that keeps the stack moving both ways,
	// one that drives it into the full state, and one that empties it again.
	typedef enum logic [1:0] {
		MIX_BALANCED,
		MIX_FILL,
		MIX_DRAIN
	} mix_t;

	// The scoreboard keeps its own copy of the stack. Every accepted request is played
	// against that copy, and the results it must cause are queued in order; every
	// accepted result is then checked against the oldest entry in the queue.
	class stack_scoreboard;
		int unsigned                  capacity;
		logic signed [WordWidth-1:0]  entries [StackDepthDefault];
		int unsigned                  filled;
		ise_res_t                     awaited_results [$];
		int unsigned                  error_count;
		int unsigned                  requests_noted;
		int unsigned                  results_checked;
		int unsigned                  peak_fill;
		int unsigned                  overflows;
		int unsigned                  refusals;
		int unsigned                  dumped_elements;

		function new(int unsigned cap);
			capacity        = cap;
			filled          = 0;
			error_count     = 0;
			requests_noted  = 0;
			results_checked = 0;
			peak_fill       = 0;
			overflows       = 0;
			refusals        = 0;
			dumped_elements = 0;
		endfunction

		function void await_result(ise_status_t st, logic signed [WordWidth-1:0] val,
				logic fin);
			ise_res_t r;
			r.status = st;
			r.value  = val;
			r.last   = fin;
			awaited_results.push_back(r);
		endfunction

		function void note_request(ise_req_t req);
			int unsigned k;
			requests_noted++;
			case (req.operation)
				OP_PUSH: begin
					if (filled >= capacity) begin
						overflows++;
						await_result(ST_OVERFLOW, WordZero, 1'b1);
					end else begin
						entries[filled] = req.push_value;
						filled++;
						await_result(ST_ACK, WordZero, 1'b1);
					end
				end
				OP_DUMP: begin
					if (filled == 0) begin
						await_result(ST_ACK, WordZero, 1'b1);
					end else begin
						// Top first; the bottom element closes the request.
						for (k = 0; k < filled; k++) begin
							await_result(ST_VALUE, entries[filled - 1 - k], k == filled - 1);
						end
						dumped_elements += filled;
					end
				end
				OP_PEEK: begin
					if (filled == 0) begin
						refusals++;
						await_result(ST_PEEK_EMPTY, WordZero, 1'b1);
					end else begin
						await_result(ST_VALUE, entries[filled - 1], 1'b1);
					end
				end
				OP_POP: begin
					if (filled == 0) begin
						refusals++;
						await_result(ST_POP_EMPTY, WordZero, 1'b1);
					end else begin
						filled--;
						await_result(ST_ACK, WordZero, 1'b1);
					end
				end
				OP_ADD: begin
					if (filled < 2) begin
						refusals++;
						await_result(ST_ADD_SHORT, WordZero, 1'b1);
					end else begin
						// The sum wraps at the word width.
						entries[filled - 2] = entries[filled - 2] + entries[filled - 1];
						filled--;
						await_result(ST_ACK, WordZero, 1'b1);
					end
				end
				default: begin
					await_result(ST_ACK, WordZero, 1'b1);
				end
			endcase
			if (filled > peak_fill) begin
				peak_fill = filled;
			end
		endfunction

		function void check_result(ise_res_t got);
			ise_res_t want;
			if (awaited_results.size() == 0) begin
				error_count++;
				$error("result with no request behind it: status %0d value %0d last %0d",
					got.status, got.value, got.last);
				return;
			end
			want = awaited_results.pop_front();
			results_checked++;
			if (got.status !== want.status) begin
				error_count++;
				$error("status: expected %0d, got %0d", want.status, got.status);
			end
			if (got.value !== want.value) begin
				error_count++;
				$error("value: expected %0d, got %0d", want.value, got.value);
			end
			if (got.last !== want.last) begin
				error_count++;
				$error("last: expected %0d, got %0d", want.last, got.last);
			end
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	ise_req_t  cmd;
	logic      res_valid;
	logic      res_stall;
	ise_res_t  res;

	stack_scoreboard stack_sb;
	int unsigned     cycle_count;

	integer_stack_engine #(
		.STACK_DEPTH(Depth)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
	end

	always #(ClkPeriod / 2) clk = ~clk;

	// The run is stopped here if the engine ever hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Results are taken at the rising edge; the stall they are taken against was set up
	// at the falling edge before, so nothing here races the engine's own registers.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			stack_sb.check_result(res);
		end
	end

	// Most gaps are absent or short, and now and then one is long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// The receiver alternates between stretches that never stall and stretches of
	// stalls with random length, so that stalls land on every phase of a request.
	initial begin
		int unsigned len;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 9) < 3) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				len = gap_len();
				if (len > 0) begin
					res_stall <= 1'b1;
					repeat (len) @(negedge clk);
				end
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
		end
	end

	// Push values lean on the extremes now and then; the rest are uniform so that
	// every bit is seen at both levels.
	function automatic logic signed [WordWidth-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return WordMax;
		end
		if (r < 6) begin
			return WordMin;
		end
		if (r < 8) begin
			return WordOnes;
		end
		if (r < 10) begin
			return WordZero;
		end
		return $urandom;
	endfunction

	// Thresholds are cumulative percentages: push, pop, add, peek, dump; the rest
	// goes to the unused opcodes.
	function automatic logic [2:0] pick_op(mix_t mix, int unsigned fill_now);
		int unsigned r;
		int unsigned t_push;
		int unsigned t_pop;
		int unsigned t_add;
		int unsigned t_peek;
		int unsigned t_dump;
		logic [2:0]  spare [3];
		spare = '{OpSpare5, OpSpare6, OpSpare7};
		case (mix)
			MIX_FILL: begin
				if (fill_now < Depth) begin
					t_push = 95; t_pop = 96; t_add = 97; t_peek = 98; t_dump = 99;
				end else begin
					t_push = 50; t_pop = 60; t_add = 70; t_peek = 80; t_dump = 95;
				end
			end
			MIX_DRAIN: begin
				t_push = 15; t_pop = 50; t_add = 80; t_peek = 87; t_dump = 95;
			end
			default: begin
				t_push = 35; t_pop = 50; t_add = 65; t_peek = 78; t_dump = 93;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < t_push) begin
			return OP_PUSH;
		end
		if (r < t_pop) begin
			return OP_POP;
		end
		if (r < t_add) begin
			return OP_ADD;
		end
		if (r < t_peek) begin
			return OP_PEEK;
		end
		if (r < t_dump) begin
			return OP_DUMP;
		end
		return spare[$urandom_range(0, 2)];
	endfunction

	// Presents one request from a falling edge and holds it until the engine takes it.
	// Valid is only lowered when a gap follows, so back-to-back requests keep it high.
	task automatic issue(logic [2:0] op, logic signed [WordWidth-1:0] val, bit gaps);
		ise_req_t    req;
		int unsigned g;
		req.operation  = ise_op_t'(op);
		req.push_value = val;
		cmd_valid <= 1'b1;
		cmd       <= req;
		do @(posedge clk); while (cmd_stall);
		stack_sb.note_request(req);
		@(negedge clk);
		if (gaps) begin
			g = gap_len();
			if (g > 0) begin
				cmd_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	endtask

	// The sender falls silent until every awaited result has come back.
	task automatic wait_until_drained();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (stack_sb.outstanding() > 0);
	endtask

	initial begin
		mix_t        plan      [6];
		int unsigned plan_len  [6];
		bit          plan_gaps [6];
		int unsigned b;
		int unsigned i;
		logic [2:0]  op;

		plan      = '{MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_DRAIN};
		plan_len  = '{60, 80, 60, 80, 40, 40};
		plan_gaps = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

		stack_sb    = new(Depth);
		cycle_count = 0;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: every refusal on an empty or short stack, the extreme values,
		// wrapping sums in both directions, a small dump and the unused opcodes.
		issue(OP_DUMP, WordZero, 1'b1);
		issue(OP_PEEK, WordZero, 1'b1);
		issue(OP_POP, WordOnes, 1'b1);
		issue(OP_ADD, WordZero, 1'b1);
		issue(OP_PUSH, WordMax, 1'b1);
		issue(OP_ADD, WordZero, 1'b1);
		issue(OP_PUSH, 32'sd1, 1'b1);
		issue(OP_ADD, WordZero, 1'b1);
		issue(OP_PEEK, WordZero, 1'b1);
		issue(OP_PUSH, WordOnes, 1'b0);
		issue(OP_PUSH, WordZero, 1'b0);
		issue(OP_PUSH, WordMin, 1'b0);
		issue(OP_DUMP, WordZero, 1'b1);
		issue(OP_ADD, WordZero, 1'b1);
		issue(OP_ADD, WordMax, 1'b1);
		issue(OpSpare5, WordZero, 1'b1);
		issue(OpSpare6, WordMin, 1'b1);
		issue(OpSpare7, WordOnes, 1'b1);
		issue(OP_PEEK, WordZero, 1'b1);
		issue(OP_POP, WordZero, 1'b1);
		issue(OP_POP, WordZero, 1'b1);
		issue(OP_POP, WordZero, 1'b1);
		issue(OP_PEEK, WordZero, 1'b1);
		wait_until_drained();

		// Random part: blocks of different mixes, each drained before the next begins.
		// The fill blocks run the stack into its full state and push against it.
		for (b = 0; b < 6; b++) begin
			for (i = 0; i < plan_len[b]; i++) begin
				op = pick_op(plan[b], stack_sb.filled);
				issue(op, pick_value(), plan_gaps[b]);
			end
			wait_until_drained();
		end

		// Anything still coming out of the engine shows up as an unexpected result here.
		repeat (TailCycles) @(negedge clk);

		$display("Covered %0d requests and %0d results; the stack reached %0d of %0d entries.",
			stack_sb.requests_noted, stack_sb.results_checked, stack_sb.peak_fill, Depth);
		$display("Saw %0d pushes refused as full, %0d refusals on a short stack, %0d dumped.",
			stack_sb.overflows, stack_sb.refusals, stack_sb.dumped_elements);
		if (stack_sb.outstanding() > 0) begin
			$error("%0d results never arrived", stack_sb.outstanding());
		end
		if (stack_sb.error_count == 0 && stack_sb.outstanding() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
